### src/mclp_pkg.sv
// ----------------------------------------------------------------------------
// mclp_pkg
// Shared constants, types and number reading for the motor command line parser.
// ----------------------------------------------------------------------------
package mclp_pkg;

	localparam int MOTOR_COUNT = 14;
	localparam int SEG_KEEP    = 5;
	localparam int LEN_W       = $clog2(SEG_KEEP + 1);

	localparam logic [7:0] CH_NL   = 8'h0A;
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	// first characters of one finished segment
	typedef logic [SEG_KEEP-1:0][7:0] seg_t;

	// front status, watched by the top level
	typedef struct packed {
		logic [LEN_W-1:0] seg_len;
		logic             hash_pending;
	} front_stat_t;

	function automatic logic is_blank(input logic [7:0] c);
		return c inside {8'h20, 8'h09, 8'h0D, 8'h0B, 8'h0C};
	endfunction

	// atol-style read over the first n characters of a group of up to three
	function automatic logic signed [10:0] read_num(input logic [2:0][7:0] ch,
			input logic [1:0] n);
		logic       in_num;
		logic       done;
		logic       neg;
		logic [9:0] v;
		logic [7:0] c;
		logic       is_dig;
		in_num = 1'b0;
		done   = 1'b0;
		neg    = 1'b0;
		v      = '0;
		for (int i = 0; i < 3; i++) begin
			c      = ch[i];
			is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
			if (2'(i) < n && !done) begin
				if (!in_num) begin
					if (is_blank(c)) begin
						in_num = 1'b0;
					end else if (c == CH_PLUS || c == CH_MINUS) begin
						neg    = (c == CH_MINUS);
						in_num = 1'b1;
					end else if (is_dig) begin
						v      = {6'd0, c[3:0]};
						in_num = 1'b1;
					end else begin
						done = 1'b1;
					end
				end else if (is_dig) begin
					v = 10'(v * 10'd10 + {6'd0, c[3:0]});
				end else begin
					done = 1'b1;
				end
			end
		end
		return neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
	endfunction

endpackage

### src/motor_command_line_parser.sv
// ----------------------------------------------------------------------------
// motor_command_line_parser
// Splits received bytes into segments and emits one motor update per valid one.
//
//   channel   handshake      payload
//   in        push / full    rx_byte
//   out       empty / pop    motor_index, drive_value
//
// One byte is taken every cycle while full is low.
// An update goes from the byte that ends its segment through the segment queue into the output register.
// full rises only when two finished segments wait behind a stalled output.
// Reset clears segment length, hash mark, queue and output valid; no sweep.
// ----------------------------------------------------------------------------
module motor_command_line_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         rx_byte,
	output logic               empty,
	input  logic               pop,
	output logic [3:0]         motor_index,
	output logic signed [10:0] drive_value
);

	logic                  accept;
	logic                  seg_push;
	mclp_pkg::seg_t        seg_wdata;
	mclp_pkg::seg_t        seg_rdata;
	logic                  seg_full;
	logic                  seg_empty;
	logic                  seg_pop;
	mclp_pkg::front_stat_t stat;

	assign full   = seg_full;
	assign accept = push && !seg_full;

	mclp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.rx_byte  (rx_byte),
		.seg_push (seg_push),
		.seg_data (seg_wdata),
		.stat     (stat)
	);

	mclp_segq u_segq (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (seg_push),
		.wr_data   (seg_wdata),
		.seg_full  (seg_full),
		.rd_en     (seg_pop),
		.rd_data   (seg_rdata),
		.seg_empty (seg_empty)
	);

	mclp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.seg_empty   (seg_empty),
		.seg_data    (seg_rdata),
		.seg_pop     (seg_pop),
		.empty       (empty),
		.pop         (pop),
		.motor_index (motor_index),
		.drive_value (drive_value)
	);

	// a newline always closes the segment and drops a held hash
	a_nl_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && rx_byte == mclp_pkg::CH_NL |=> stat.seg_len == '0 && !stat.hash_pending)
		else $error("newline did not close segment");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.seg_len <= mclp_pkg::LEN_W'(mclp_pkg::SEG_KEEP))
		else $error("segment length past limit");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> motor_index < 4'(mclp_pkg::MOTOR_COUNT))
		else $error("motor index out of range");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(seg_push && seg_full))
		else $error("segment queue overrun");

endmodule

### src/mclp_front.sv
// ----------------------------------------------------------------------------
// mclp_front
// Takes bytes, tracks the current segment and hands off finished segments.
// ----------------------------------------------------------------------------
module mclp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           rx_byte,
	output logic                 seg_push,
	output mclp_pkg::seg_t       seg_data,
	output mclp_pkg::front_stat_t stat
);

	mclp_pkg::seg_t                 chars_q;
	logic [mclp_pkg::LEN_W-1:0]     len_q;
	logic                           hash_q;

	mclp_pkg::seg_t                 chars_d;
	logic [mclp_pkg::LEN_W-1:0]     len1;
	logic [mclp_pkg::LEN_W-1:0]     len_d;
	logic                           hash_d;
	logic                           emit;

	localparam logic [mclp_pkg::LEN_W-1:0] KEEP = mclp_pkg::LEN_W'(mclp_pkg::SEG_KEEP);

	always_comb begin
		chars_d = chars_q;
		len1    = len_q;
		emit    = 1'b0;
		len_d   = len_q;
		hash_d  = 1'b0;
		// a held-back hash becomes an ordinary character unless a newline follows
		if (hash_q && len_q < KEEP && rx_byte != mclp_pkg::CH_NL) begin
			chars_d[len_q] = mclp_pkg::CH_HASH;
			len1           = len_q + 1'b1;
		end
		case (rx_byte)
			mclp_pkg::CH_NL: begin
				emit  = (len_q == KEEP);
				len_d = '0;
			end
			mclp_pkg::CH_AMP: begin
				emit  = (len1 == KEEP);
				len_d = '0;
			end
			mclp_pkg::CH_HASH: begin
				len_d  = len1;
				hash_d = 1'b1;
			end
			default: begin
				if (len1 < KEEP) begin
					chars_d[len1] = rx_byte;
					len_d         = len1 + 1'b1;
				end else begin
					len_d = len1;
				end
			end
		endcase
	end

	assign seg_push          = accept && emit;
	assign seg_data          = chars_d;
	assign stat.seg_len      = len_q;
	assign stat.hash_pending = hash_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			chars_q <= chars_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			hash_q <= 1'b0;
		end else if (accept) begin
			len_q  <= len_d;
			hash_q <= hash_d;
		end
	end

endmodule

### src/mclp_segq.sv
// ----------------------------------------------------------------------------
// mclp_segq
// Two-entry queue of finished segments between the front and the back.
// ----------------------------------------------------------------------------
module mclp_segq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  mclp_pkg::seg_t wr_data,
	output logic           seg_full,
	input  logic           rd_en,
	output mclp_pkg::seg_t rd_data,
	output logic           seg_empty
);

	mclp_pkg::seg_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign seg_full  = (count_q == 2'd2);
	assign seg_empty = (count_q == 2'd0);
	assign rd_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### src/mclp_back.sv
// ----------------------------------------------------------------------------
// mclp_back
// Reads motor number and drive value from a segment and holds the update.
// ----------------------------------------------------------------------------
module mclp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                seg_empty,
	input  mclp_pkg::seg_t      seg_data,
	output logic                seg_pop,
	output logic                empty,
	input  logic                pop,
	output logic [3:0]          motor_index,
	output logic signed [10:0]  drive_value
);

	logic                valid_q;
	logic [3:0]          index_q;
	logic signed [10:0]  value_q;

	logic signed [10:0]  num_n;
	logic signed [10:0]  num_v;
	logic signed [10:0]  idx_m1;
	logic                idx_ok;
	logic                take;

	assign num_n  = mclp_pkg::read_num({8'h00, seg_data[1], seg_data[0]}, 2'd2);
	assign num_v  = mclp_pkg::read_num({seg_data[4], seg_data[3], seg_data[2]}, 2'd3);
	assign idx_m1 = num_n - 11'sd1;
	assign idx_ok = (idx_m1 >= 11'sd0) &&
		(idx_m1 < $signed(11'(mclp_pkg::MOTOR_COUNT)));

	// output slot frees when empty or when its update is taken this cycle
	assign take    = !seg_empty && (!valid_q || pop);
	assign seg_pop = take;

	assign empty       = !valid_q;
	assign motor_index = index_q;
	assign drive_value = value_q;

	always_ff @(posedge clk) begin
		if (take) begin
			index_q <= idx_m1[3:0];
			value_q <= num_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= idx_ok;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

endmodule

### test/tb_motor_command_line_parser.sv
// ----------------------------------------------------------------------------
// tb_motor_command_line_parser
// Streams command bytes through the parser and checks every motor update
// against a behavioral copy of the segment logic kept inside the bench.
// Directed lines cover the field extremes and hash handling. The random part
// is mostly well-formed segments, with noise and broken segments mixed in.
// Both sides idle at random, and one long output stall fills the block.
// ----------------------------------------------------------------------------
module tb_motor_command_line_parser;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_BYTES = 1350;
	localparam int IDLE_LIMIT   = 5000;
	localparam int HOLD_CYCLES  = 400;
	localparam int SEG_WIDTH    = 5;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;

	typedef struct {
		logic [3:0]         motor;
		logic signed [10:0] drive;
	} motor_update_t;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [7:0]         rx_byte;
	logic               empty;
	logic               pop;
	logic [3:0]         motor_index;
	logic signed [10:0] drive_value;

	logic [7:0]    byte_queue[$];
	motor_update_t motor_updates[$];

	// parser state as the bench sees it
	logic [7:0] seg_chars[SEG_WIDTH];
	int         seg_len;
	bit         hash_held;

	int  errors;
	int  bytes_taken;
	int  updates_seen;
	int  full_cycles;
	int  cycle_count;
	int  idle_cycles;
	int  send_gap;
	int  recv_gap;
	logic hold_pop;

	motor_command_line_parser u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.rx_byte     (rx_byte),
		.empty       (empty),
		.pop         (pop),
		.motor_index (motor_index),
		.drive_value (drive_value)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	task automatic report_mismatch(input string msg);
		errors++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	function automatic bit is_space(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF;
	endfunction

	// atol over a group of stored segment characters
	function automatic int parse_group(input int start, input int count);
		int pos;
		int stop;
		int acc;
		bit minus;
		pos   = start;
		stop  = start + count;
		acc   = 0;
		minus = 1'b0;
		while (pos < stop && is_space(seg_chars[pos])) pos++;
		if (pos < stop && (seg_chars[pos] == mclp_pkg::CH_PLUS ||
				seg_chars[pos] == mclp_pkg::CH_MINUS)) begin
			minus = seg_chars[pos] == mclp_pkg::CH_MINUS;
			pos++;
		end
		while (pos < stop && seg_chars[pos] >= mclp_pkg::CH_ZERO &&
				seg_chars[pos] <= mclp_pkg::CH_NINE) begin
			acc = acc * 10 + int'(seg_chars[pos] - mclp_pkg::CH_ZERO);
			pos++;
		end
		return minus ? -acc : acc;
	endfunction

	function automatic void keep_char(input logic [7:0] c);
		if (seg_len < SEG_WIDTH) begin
			seg_chars[seg_len] = c;
			seg_len++;
		end
	endfunction

	function automatic void close_segment();
		int            motor;
		int            drive;
		motor_update_t upd;
		if (seg_len >= SEG_WIDTH) begin
			motor = parse_group(0, 2) - 1;
			drive = parse_group(2, 3);
			if (motor >= 0 && motor < mclp_pkg::MOTOR_COUNT) begin
				upd.motor = 4'(motor);
				upd.drive = 11'(drive);
				motor_updates.push_back(upd);
			end
		end
		seg_len   = 0;
		hash_held = 1'b0;
	endfunction

	function automatic void parse_byte(input logic [7:0] b);
		if (b == mclp_pkg::CH_NL) begin
			close_segment();
			return;
		end
		// a held hash is an ordinary character unless a newline follows
		if (hash_held) keep_char(mclp_pkg::CH_HASH);
		if (b == mclp_pkg::CH_AMP) begin
			close_segment();
			return;
		end
		if (b == mclp_pkg::CH_HASH) begin
			hash_held = 1'b1;
			return;
		end
		hash_held = 1'b0;
		keep_char(b);
	endfunction

	function automatic int pick_gap();
		int r;
		if (cycle_count % 1024 < 256) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 4))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_CR;
			3: return CH_VT;
			default: return CH_FF;
		endcase
	endfunction

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) byte_queue.push_back(s[i]);
	endtask

	// one segment of a command line, mostly well formed
	task automatic build_segment();
		logic [7:0] seg[$];
		string      idx_s;
		string      val_s;
		string      txt;
		int         motor;
		int         drive;
		int         sel;
		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			// noise
			repeat ($urandom_range(1, 8)) byte_queue.push_back(8'($urandom_range(0, 255)));
			return;
		end
		if (sel < 13) begin
			// short segment
			repeat ($urandom_range(0, 4)) byte_queue.push_back(8'($urandom_range(8'h30, 8'h39)));
			byte_queue.push_back($urandom_range(0, 1) ? mclp_pkg::CH_AMP : mclp_pkg::CH_NL);
			return;
		end
		motor = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 14);
		case ($urandom_range(0, 3))
			0: idx_s = $sformatf("%02d", motor);
			1: idx_s = $sformatf("%2d", motor);
			2: idx_s = (motor < 10) ? $sformatf("+%0d", motor) : $sformatf("%02d", motor);
			default: idx_s = ($urandom_range(0, 3) == 0) ? "-1" : $sformatf("%02d", motor);
		endcase
		drive = $urandom_range(0, 1098) - 99;
		if (drive >= 0) begin
			case ($urandom_range(0, 2))
				0: val_s = $sformatf("%03d", drive);
				1: val_s = $sformatf("%3d", drive);
				default: val_s = (drive < 100) ? $sformatf("+%02d", drive) : $sformatf("%03d", drive);
			endcase
		end else if (drive <= -10) begin
			val_s = $sformatf("-%02d", -drive);
		end else begin
			val_s = $urandom_range(0, 1) ? $sformatf(" -%0d", -drive) : $sformatf("-%0d ", -drive);
		end
		txt = {idx_s, val_s};
		for (int i = 0; i < txt.len(); i++) begin
			if (txt[i] == CH_SPACE && $urandom_range(0, 1)) seg.push_back(pick_blank());
			else seg.push_back(txt[i]);
		end
		if ($urandom_range(0, 9) == 0) seg[$urandom_range(0, seg.size() - 1)] = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 9) == 0) seg.insert($urandom_range(0, seg.size()), mclp_pkg::CH_HASH);
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 4)) seg.push_back(8'($urandom_range(8'h21, 8'h7E)));
		end
		case ($urandom_range(0, 4))
			0, 1: seg.push_back(mclp_pkg::CH_AMP);
			2: seg.push_back(mclp_pkg::CH_NL);
			3: begin
				seg.push_back(mclp_pkg::CH_HASH);
				seg.push_back(mclp_pkg::CH_NL);
			end
			default: begin
				seg.push_back(mclp_pkg::CH_HASH);
				seg.push_back(mclp_pkg::CH_AMP);
			end
		endcase
		foreach (seg[i]) byte_queue.push_back(seg[i]);
	endtask

	// sender
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (send_gap > 0) begin
			push <= 1'b0;
			send_gap--;
		end else if (byte_queue.size() > 0) begin
			push    <= 1'b1;
			rx_byte <= byte_queue[0];
		end else begin
			push <= 1'b0;
		end
	end

	// receiver
	always @(negedge clk) begin
		if (!arst_n || hold_pop) begin
			pop <= 1'b0;
		end else if (recv_gap > 0) begin
			pop <= 1'b0;
			recv_gap--;
		end else begin
			pop <= 1'b1;
		end
	end

	// input side: every accepted byte steps the predictor
	always @(posedge clk) begin
		cycle_count++;
		if (arst_n && push && full) full_cycles++;
		if (arst_n && push && !full) begin
			parse_byte(rx_byte);
			void'(byte_queue.pop_front());
			bytes_taken++;
			send_gap = pick_gap();
		end
	end

	// output side
	always @(posedge clk) begin
		motor_update_t want;
		if (arst_n && pop && !empty) begin
			updates_seen++;
			if (motor_updates.size() == 0) begin
				report_mismatch($sformatf("unexpected update motor %0d drive %0d",
					motor_index, drive_value));
			end else begin
				want = motor_updates.pop_front();
				if (motor_index !== want.motor)
					report_mismatch($sformatf("motor_index %0d, want %0d",
						motor_index, want.motor));
				if (drive_value !== want.drive)
					report_mismatch($sformatf("drive_value %0d, want %0d",
						drive_value, want.drive));
			end
			recv_gap = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
				$display("tb_motor_command_line_parser NOT OK");
				$finish;
			end
		end
	end

	// long output stall so that finished segments pile up
	initial begin
		hold_pop = 1'b0;
		while (bytes_taken < 300) @(negedge clk);
		hold_pop <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_pop <= 1'b0;
	end

	initial begin
		arst_n       = 1'b0;
		push         = 1'b0;
		pop          = 1'b0;
		rx_byte      = '0;
		errors       = 0;
		bytes_taken  = 0;
		updates_seen = 0;
		full_cycles  = 0;
		cycle_count  = 0;
		idle_cycles  = 0;
		send_gap     = 0;
		recv_gap     = 0;
		seg_len      = 0;
		hash_held    = 1'b0;

		// extremes, continuation hash, ordinary hash, long line, bad index
		push_text("01999&");
		push_text("14-99");
		byte_queue.push_back(mclp_pkg::CH_HASH);
		byte_queue.push_back(mclp_pkg::CH_NL);
		push_text("7#5+3x");
		byte_queue.push_back(mclp_pkg::CH_NL);
		push_text("00");
		byte_queue.push_back(8'hFF);
		byte_queue.push_back(8'h00);
		byte_queue.push_back(mclp_pkg::CH_HASH);
		byte_queue.push_back(mclp_pkg::CH_AMP);
		while (byte_queue.size() < 26 + RANDOM_BYTES) build_segment();
		byte_queue.push_back(mclp_pkg::CH_AMP);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (byte_queue.size() > 0 || motor_updates.size() > 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (motor_updates.size() != 0)
			report_mismatch($sformatf("%0d updates never arrived", motor_updates.size()));

		$display("sent %0d bytes, checked %0d motor updates", bytes_taken, updates_seen);
		$display("input held off by full for %0d cycles", full_cycles);
		if (errors == 0) begin
			$display("tb_motor_command_line_parser OK");
		end else begin
			$display("tb_motor_command_line_parser NOT OK");
		end
		$finish;
	end

endmodule
